FILE: rtl/core/fawarp_pkg.sv
// Shared types and constants for the forward affine nearest-neighbor warp.
`default_nettype none

package fawarp_pkg;

    typedef logic        [7:0]  pix_t;
    typedef logic signed [31:0] coef_t;
    typedef logic        [9:0]  coord_t;
    typedef logic        [10:0] size_t;
    typedef logic        [2:0]  reg_idx_t;

    // register indexes on the configuration port
    localparam reg_idx_t REG_COEF_A     = 3'd0;
    localparam reg_idx_t REG_COEF_B     = 3'd1;
    localparam reg_idx_t REG_COEF_C     = 3'd2;
    localparam reg_idx_t REG_COEF_D     = 3'd3;
    localparam reg_idx_t REG_COEF_E     = 3'd4;
    localparam reg_idx_t REG_COEF_F     = 3'd5;
    localparam reg_idx_t REG_SRC_WIDTH  = 3'd6;
    localparam reg_idx_t REG_SRC_HEIGHT = 3'd7;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // reset values of the configuration registers
    localparam coef_t RST_COEF_A = 32'sd41066;
    localparam coef_t RST_COEF_B = -32'sd6571;
    localparam coef_t RST_COEF_C = 32'sd8334117;
    localparam coef_t RST_COEF_D = 32'sd7972;
    localparam coef_t RST_COEF_E = 32'sd39837;
    localparam coef_t RST_COEF_F = 32'sd828977;
    localparam size_t SRC_MAX    = 11'd1024;

    // fixed-point rounding: add one half in Q.16, then floor
    localparam int    Q_FRAC   = 16;
    localparam int    SUM_W    = 45;
    localparam int    COORD_W  = SUM_W - Q_FRAC;
    localparam logic signed [SUM_W-1:0] HALF_Q16 = 45'sd32768;

endpackage

`default_nettype wire

FILE: rtl/core/forward_affine_nearest_warp.sv
// Forward affine warp: source pixels are placed into an output frame store by rounding.
//
// Usage: requests enter on in_valid/in_stall. A request with cmd = push carries one
// source pixel in raster order; the block maps its (column, row) through the affine
// coefficients, rounds to the nearest pixel and writes it into the frame store.
// A request with cmd = read returns one stored pixel and clears that entry.
// Every request yields exactly one result on out_valid/out_stall.
// Steps: a push passes multiply, sum and round, then store write; a read passes
// memory read, then clear write. One request is in flight at a time: no new request
// is accepted until the current one has loaded its result. The single frame store
// port and the multiply-add chain shape these steps.
// Reset: the counters and configuration take their reset values, then a clearing
// pass writes zero to all OUT_W*OUT_H store entries, one per cycle, with in_stall
// held high; configuration writes are taken during the pass.
// Stall: a finished result waits in the output register while out_stall is high;
// the next request may be accepted meanwhile, but it does not finish until the
// output register is free.
`default_nettype none

module forward_affine_nearest_warp #(
    parameter int OUT_W = 1024,
    parameter int OUT_H = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire fawarp_pkg::reg_idx_t cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               cmd,
    input  wire fawarp_pkg::pix_t   pixel_in,
    input  wire fawarp_pkg::coord_t read_x,
    input  wire fawarp_pkg::coord_t read_y,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    landed,
    output fawarp_pkg::coord_t      dest_x,
    output fawarp_pkg::coord_t      dest_y,
    output fawarp_pkg::pix_t        read_value
);
    import fawarp_pkg::*;

    localparam int DEPTH  = OUT_W * OUT_H;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int XW     = $clog2(OUT_W);
    localparam int YW     = $clog2(OUT_H);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_RDATA = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [ADDR_W-1:0]       clr_addr_reg;

    coef_t coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg, coef_e_reg, coef_f_reg;
    size_t src_width_reg, src_height_reg;
    coord_t col_count_reg, row_count_reg;

    pix_t                    pix_reg;
    logic [ADDR_W-1:0]       rd_addr_reg;
    logic                    rd_ok_reg;
    pix_t                    rd_data_reg;
    logic signed [42:0]      prod_ac_reg, prod_br_reg, prod_dc_reg, prod_er_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg;

    logic                    out_valid_reg;
    logic                    landed_reg;
    coord_t                  dest_x_reg, dest_y_reg;
    pix_t                    read_value_reg;

    pix_t                    frame_mem [0:DEPTH-1];

    logic                    accept, out_free, out_load;
    size_t                   w_eff, h_eff;
    logic                    col_wrap, row_wrap;
    logic [31:0]             rd_lin, wr_lin;
    logic                    rd_ok;
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic                    in_store;
    logic                    mem_we, mem_re;
    logic [ADDR_W-1:0]       mem_waddr;
    pix_t                    mem_wdata;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = out_free && ((state_reg == S_WRITE) || (state_reg == S_RDATA));

    // effective source size: zero acts as one, oversize clamps
    always_comb
    begin
        w_eff = src_width_reg;
        h_eff = src_height_reg;
        if (src_width_reg == 11'd0)
        begin
            w_eff = 11'd1;
        end
        else if (src_width_reg > SRC_MAX)
        begin
            w_eff = SRC_MAX;
        end
        if (src_height_reg == 11'd0)
        begin
            h_eff = 11'd1;
        end
        else if (src_height_reg > SRC_MAX)
        begin
            h_eff = SRC_MAX;
        end
    end

    assign col_wrap = ({1'b0, col_count_reg} + 11'd1) >= w_eff;
    assign row_wrap = ({1'b0, row_count_reg} + 11'd1) >= h_eff;

    assign rd_ok  = (32'(read_x) < 32'(OUT_W)) && (32'(read_y) < 32'(OUT_H));
    assign rd_lin = 32'(read_y) * 32'(OUT_W) + 32'(read_x);

    assign sum_x = SUM_W'(prod_ac_reg) + SUM_W'(prod_br_reg) + SUM_W'(coef_c_reg) + HALF_Q16;
    assign sum_y = SUM_W'(prod_dc_reg) + SUM_W'(prod_er_reg) + SUM_W'(coef_f_reg) + HALF_Q16;

    assign in_store = !x_reg[COORD_W-1] && !y_reg[COORD_W-1]
                      && (x_reg[COORD_W-2:0] < (COORD_W-1)'(OUT_W))
                      && (y_reg[COORD_W-2:0] < (COORD_W-1)'(OUT_H));
    assign wr_lin = 32'(y_reg[YW-1:0]) * 32'(OUT_W) + 32'(x_reg[XW-1:0]);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cmd == CMD_READ) ? S_RDATA : S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_WRITE;
            end
            S_WRITE, S_RDATA:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // single store port: clearing pass, pixel write, or clear-on-read
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (out_load && (state_reg == S_WRITE))
        begin
            mem_we    = in_store;
            mem_waddr = wr_lin[ADDR_W-1:0];
            mem_wdata = pix_reg;
        end
        else if (out_load && (state_reg == S_RDATA))
        begin
            mem_we    = rd_ok_reg;
            mem_waddr = rd_addr_reg;
        end
    end

    assign mem_re = accept && (cmd == CMD_READ) && rd_ok;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= frame_mem[rd_lin[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            coef_a_reg     <= RST_COEF_A;
            coef_b_reg     <= RST_COEF_B;
            coef_c_reg     <= RST_COEF_C;
            coef_d_reg     <= RST_COEF_D;
            coef_e_reg     <= RST_COEF_E;
            coef_f_reg     <= RST_COEF_F;
            src_width_reg  <= SRC_MAX;
            src_height_reg <= SRC_MAX;
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COEF_A:     coef_a_reg     <= cfg_data;
                    REG_COEF_B:     coef_b_reg     <= cfg_data;
                    REG_COEF_C:     coef_c_reg     <= cfg_data;
                    REG_COEF_D:     coef_d_reg     <= cfg_data;
                    REG_COEF_E:     coef_e_reg     <= cfg_data;
                    REG_COEF_F:     coef_f_reg     <= cfg_data;
                    REG_SRC_WIDTH:  src_width_reg  <= cfg_data[10:0];
                    REG_SRC_HEIGHT: src_height_reg <= cfg_data[10:0];
                    default:        ;
                endcase
            end
            // advance raster position on every push
            if (accept && (cmd == CMD_PUSH))
            begin
                if (col_wrap)
                begin
                    col_count_reg <= '0;
                    row_count_reg <= row_wrap ? '0 : row_count_reg + 10'd1;
                end
                else
                begin
                    col_count_reg <= col_count_reg + 10'd1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg     <= pixel_in;
            rd_addr_reg <= rd_lin[ADDR_W-1:0];
            rd_ok_reg   <= rd_ok;
            prod_ac_reg <= 43'(coef_a_reg * $signed({1'b0, col_count_reg}));
            prod_br_reg <= 43'(coef_b_reg * $signed({1'b0, row_count_reg}));
            prod_dc_reg <= 43'(coef_d_reg * $signed({1'b0, col_count_reg}));
            prod_er_reg <= 43'(coef_e_reg * $signed({1'b0, row_count_reg}));
        end
        if (state_reg == S_CALC)
        begin
            x_reg <= sum_x[SUM_W-1:Q_FRAC];
            y_reg <= sum_y[SUM_W-1:Q_FRAC];
        end
        if (out_load)
        begin
            if (state_reg == S_WRITE)
            begin
                landed_reg     <= in_store;
                dest_x_reg     <= in_store ? x_reg[9:0] : '0;
                dest_y_reg     <= in_store ? y_reg[9:0] : '0;
                read_value_reg <= '0;
            end
            else
            begin
                landed_reg     <= 1'b0;
                dest_x_reg     <= '0;
                dest_y_reg     <= '0;
                read_value_reg <= rd_ok_reg ? rd_data_reg : '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign landed     = landed_reg;
    assign dest_x     = dest_x_reg;
    assign dest_y     = dest_y_reg;
    assign read_value = read_value_reg;

    // no result appears while the store is being cleared
    a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !out_valid_reg)
        else $error("result during clearing pass");

    // a new result is loaded only from a finishing state
    a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |->
        ($past(state_reg) == S_WRITE || $past(state_reg) == S_RDATA))
        else $error("result loaded from wrong state");

    // a read request leaves the raster counters alone
    a_read_keeps_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_READ)) |=> ($stable(col_count_reg) && $stable(row_count_reg)))
        else $error("counters moved on read");

    // a push that does not wrap steps the column by one
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_PUSH) && !col_wrap) |=>
        (col_count_reg == $past(col_count_reg) + 10'd1))
        else $error("column counter did not advance");

endmodule

`default_nettype wire
